// File: rtl/mfam_pkg.sv
`default_nettype none
package mfam_pkg;

  localparam int RING_FRAMES = 4096;
  localparam int PTR_W       = $clog2(RING_FRAMES);
  localparam int LEN_W       = 13;
  localparam int SAMPLE_W    = 16;
  localparam int CNT_W       = 32;
  localparam int FILL_W      = 12;
  localparam int WORD_W      = 2 * SAMPLE_W;

  localparam int IN_FIELDS_W  = LEN_W + 2 * SAMPLE_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 2 * SAMPLE_W + FILL_W + 2 * CNT_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_MIX  = 1'b1
  } op_t;

  // per-item decision, captured at the input transfer
  typedef struct packed {
    logic              use_ring;
    logic              took;
    logic [FILL_W-1:0] fill;
    logic [CNT_W-1:0]  dropped;
    logic [CNT_W-1:0]  underflow;
  } status_t;

endpackage
`default_nettype wire

// File: rtl/monitor_fifo_attenuated_mixer_unit.sv
`default_nettype none
// Monitor ring FIFO of 4096 stereo frames (4095 usable) feeding a saturating mixer.
// Push transfers store monitor frames, whole blocks being dropped when they do not
// fit; mix transfers add three quarters of the oldest monitor frame to the host
// frame. An item's transfer updates the pointers and accesses the single-port
// ring memory; the read data is mixed and registered once the output is free.
// A new item is taken while the previous result still waits in the output register.
module monitor_fifo_attenuated_mixer_unit (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic                               cfg_data,     // monitor_enable
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  // block_frames, left_in, right_in
  input  wire logic [mfam_pkg::IN_DATA_W-1:0]     s_tdata,
  input  wire logic [1:0]                         s_tuser,      // op, first_of_block
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // left_out, right_out, fill_frames, drop_count, underflow_count
  output logic      [mfam_pkg::OUT_DATA_W-1:0]    m_tdata,
  output logic      [0:0]                         m_tuser       // took_effect
);

  localparam int SW = mfam_pkg::SAMPLE_W;
  localparam int LW = mfam_pkg::LEN_W;

  typedef enum logic {
    ST_IDLE,
    ST_CALC
  } state_t;

  state_t                        state;
  logic                          in_xfer;
  logic                          out_free;
  logic                          ram_en, ram_we;
  logic [mfam_pkg::PTR_W-1:0]    ram_addr;
  logic [mfam_pkg::WORD_W-1:0]   ram_wdata, ram_rdata;
  mfam_pkg::status_t             status;
  logic signed [SW-1:0]          host_left, host_right;
  logic signed [SW-1:0]          mix_left, mix_right;
  logic [mfam_pkg::OUT_FIELDS_W-1:0] out_fields;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign in_xfer   = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  mfam_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_valid && cfg_ready),
    .cfg_enable (cfg_data),
    .accept     (in_xfer),
    .op         (mfam_pkg::op_t'(s_tuser[0])),
    .first      (s_tuser[1]),
    .len        (s_tdata[LW-1:0]),
    .push_word  (s_tdata[LW+2*SW-1:LW]),
    .ram_en     (ram_en),
    .ram_we     (ram_we),
    .ram_addr   (ram_addr),
    .ram_wdata  (ram_wdata),
    .status     (status)
  );

  mfam_ram #(
    .DEPTH (mfam_pkg::RING_FRAMES),
    .WIDTH (mfam_pkg::WORD_W)
  ) u_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // push items report zero samples
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      if (mfam_pkg::op_t'(s_tuser[0]) == mfam_pkg::OP_MIX) begin
        host_left  <= s_tdata[LW+SW-1:LW];
        host_right <= s_tdata[LW+2*SW-1:LW+SW];
      end else begin
        host_left  <= '0;
        host_right <= '0;
      end
    end
  end

  mfam_mix u_mix (
    .use_ring   (status.use_ring),
    .host_left  (host_left),
    .host_right (host_right),
    .ring_word  (ram_rdata),
    .left_out   (mix_left),
    .right_out  (mix_right)
  );

  assign out_fields = {status.underflow, status.dropped, status.fill, mix_right, mix_left};

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
          end
          if (in_xfer) begin
            state <= ST_CALC;
          end
        end
        ST_CALC: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= mfam_pkg::OUT_DATA_W'(out_fields);
            m_tuser  <= status.took;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // one item in flight at a time
  assert property (@(posedge clk) disable iff (rst) in_xfer |=> !s_tready)
    else $error("input taken while an item is in flight");

  // counters only move with an input transfer
  assert property (@(posedge clk) disable iff (rst)
    !in_xfer |=> $stable(status.underflow) && $stable(status.dropped))
    else $error("status changed without an input transfer");

  // a finished result waits while the output is stalled
  assert property (@(posedge clk) disable iff (rst)
    state == ST_CALC && m_tvalid && !m_tready |=> state == ST_CALC)
    else $error("result left calc while output stalled");

endmodule
`default_nettype wire

// File: rtl/mfam_ram.sv
`default_nettype none
module mfam_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/mfam_ctrl.sv
`default_nettype none
module mfam_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic                          cfg_enable,
  input  wire logic                          accept,
  input  wire mfam_pkg::op_t                 op,
  input  wire logic                          first,
  input  wire logic [mfam_pkg::LEN_W-1:0]    len,
  input  wire logic [mfam_pkg::WORD_W-1:0]   push_word,
  output logic                               ram_en,
  output logic                               ram_we,
  output logic      [mfam_pkg::PTR_W-1:0]    ram_addr,
  output logic      [mfam_pkg::WORD_W-1:0]   ram_wdata,
  output mfam_pkg::status_t                  status
);

  localparam logic [mfam_pkg::PTR_W-1:0] LAST_SLOT = mfam_pkg::PTR_W'(mfam_pkg::RING_FRAMES - 1);

  logic [mfam_pkg::PTR_W-1:0] write_ptr, write_ptr_next;
  logic [mfam_pkg::PTR_W-1:0] read_ptr, read_ptr_next;
  logic                       flush_req, flush_req_next;
  logic                       push_block_ok, push_block_ok_next;
  logic                       mix_call_bypass, mix_call_bypass_next;
  logic                       monitor_enable;
  logic [mfam_pkg::CNT_W-1:0] dropped_total, dropped_total_next;
  logic [mfam_pkg::CNT_W-1:0] underflow_total, underflow_total_next;
  logic [mfam_pkg::PTR_W:0]   used, used_after, free_slots;
  logic                       took, use_ring;

  function automatic logic [mfam_pkg::PTR_W:0] ring_used(
    input logic [mfam_pkg::PTR_W-1:0] wp,
    input logic [mfam_pkg::PTR_W-1:0] rp
  );
    logic [mfam_pkg::PTR_W:0] d;
    d = {1'b0, wp} - {1'b0, rp};
    if (wp < rp) begin
      d = d + (mfam_pkg::PTR_W+1)'(mfam_pkg::RING_FRAMES);
    end
    return d;
  endfunction

  function automatic logic [mfam_pkg::PTR_W-1:0] ring_next(
    input logic [mfam_pkg::PTR_W-1:0] p
  );
    return (p == LAST_SLOT) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    write_ptr_next       = write_ptr;
    read_ptr_next        = read_ptr;
    flush_req_next       = flush_req;
    push_block_ok_next   = push_block_ok;
    mix_call_bypass_next = mix_call_bypass;
    dropped_total_next   = dropped_total;
    underflow_total_next = underflow_total;
    took                 = 1'b0;
    use_ring             = 1'b0;
    ram_en               = 1'b0;
    ram_we               = 1'b0;
    ram_addr             = read_ptr;
    ram_wdata            = push_word;
    used       = ring_used(write_ptr, read_ptr);
    free_slots = (mfam_pkg::PTR_W+1)'(mfam_pkg::RING_FRAMES - 1) - used;

    if (accept) begin
      if (op == mfam_pkg::OP_PUSH) begin
        if (first) begin
          if (len == '0) begin
            push_block_ok_next = 1'b0;
          end else if (32'(len) > 32'(free_slots)) begin
            push_block_ok_next = 1'b0;
            dropped_total_next = dropped_total + mfam_pkg::CNT_W'(len);
          end else begin
            push_block_ok_next = 1'b1;
          end
        end
        if (push_block_ok_next &&
            (used < (mfam_pkg::PTR_W+1)'(mfam_pkg::RING_FRAMES - 1))) begin
          ram_en         = 1'b1;
          ram_we         = 1'b1;
          ram_addr       = write_ptr;
          write_ptr_next = ring_next(write_ptr);
          took           = 1'b1;
        end
      end else begin
        if (first) begin
          if (len == '0) begin
            mix_call_bypass_next = 1'b1;
          end else if (!monitor_enable || flush_req) begin
            read_ptr_next        = write_ptr;
            flush_req_next       = 1'b0;
            mix_call_bypass_next = 1'b1;
          end else begin
            mix_call_bypass_next = 1'b0;
          end
        end
        if (!mix_call_bypass_next) begin
          if (used != '0) begin
            ram_en        = 1'b1;
            ram_addr      = read_ptr;
            read_ptr_next = ring_next(read_ptr);
            took          = 1'b1;
            use_ring      = 1'b1;
          end else begin
            underflow_total_next = underflow_total + 1'b1;
          end
        end
      end
    end

    if (cfg_write) begin
      flush_req_next = 1'b1;
    end
    used_after = ring_used(write_ptr_next, read_ptr_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_ptr       <= '0;
      read_ptr        <= '0;
      flush_req       <= 1'b1;
      push_block_ok   <= 1'b0;
      mix_call_bypass <= 1'b0;
      monitor_enable  <= 1'b0;
      dropped_total   <= '0;
      underflow_total <= '0;
    end else begin
      write_ptr       <= write_ptr_next;
      read_ptr        <= read_ptr_next;
      flush_req       <= flush_req_next;
      push_block_ok   <= push_block_ok_next;
      mix_call_bypass <= mix_call_bypass_next;
      dropped_total   <= dropped_total_next;
      underflow_total <= underflow_total_next;
      if (cfg_write) begin
        monitor_enable <= cfg_enable;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      status <= '0;
    end else if (accept) begin
      status.use_ring  <= use_ring;
      status.took      <= took;
      status.fill      <= mfam_pkg::FILL_W'(used_after);
      status.dropped   <= dropped_total_next;
      status.underflow <= underflow_total_next;
    end
  end

endmodule
`default_nettype wire

// File: rtl/mfam_mix.sv
`default_nettype none
module mfam_mix (
  input  wire logic                                use_ring,
  input  wire logic signed [mfam_pkg::SAMPLE_W-1:0] host_left,
  input  wire logic signed [mfam_pkg::SAMPLE_W-1:0] host_right,
  input  wire logic        [mfam_pkg::WORD_W-1:0]   ring_word,
  output logic signed      [mfam_pkg::SAMPLE_W-1:0] left_out,
  output logic signed      [mfam_pkg::SAMPLE_W-1:0] right_out
);

  localparam int SW = mfam_pkg::SAMPLE_W;

  // three quarters, truncated toward zero, then added with saturation
  function automatic logic signed [SW-1:0] mix_one(
    input logic signed [SW-1:0] host,
    input logic signed [SW-1:0] mon
  );
    logic signed [SW+1:0] prod;
    logic signed [SW+1:0] biased;
    logic signed [SW-1:0] quarter3;
    logic signed [SW:0]   sum;
    prod   = (SW+2)'(mon) + ((SW+2)'(mon) <<< 1);
    biased = prod + ((prod < 0) ? (SW+2)'(3) : (SW+2)'(0));
    quarter3 = SW'(biased >>> 2);
    sum = (SW+1)'(host) + (SW+1)'(quarter3);
    if (sum > (SW+1)'(32767)) begin
      return SW'(32767);
    end else if (sum < -(SW+1)'(32768)) begin
      return SW'(-32768);
    end
    return SW'(sum);
  endfunction

  always_comb begin
    if (use_ring) begin
      left_out  = mix_one(host_left, ring_word[SW-1:0]);
      right_out = mix_one(host_right, ring_word[2*SW-1:SW]);
    end else begin
      left_out  = host_left;
      right_out = host_right;
    end
  end

endmodule
`default_nettype wire

// File: tb/monitor_fifo_attenuated_mixer_unit_test.sv
`default_nettype none
module monitor_fifo_attenuated_mixer_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import mfam_pkg::*;

  localparam int SAMPLE_MAX = 32767;
  localparam int SAMPLE_MIN = -32768;
  localparam int LEFT_LO    = 0;
  localparam int RIGHT_LO   = SAMPLE_W;
  localparam int FILL_LO    = 2 * SAMPLE_W;
  localparam int DROP_LO    = FILL_LO + FILL_W;
  localparam int UFLOW_LO   = DROP_LO + CNT_W;

  typedef struct {
    logic [SAMPLE_W-1:0] left;
    logic [SAMPLE_W-1:0] right;
    logic                took;
    logic [FILL_W-1:0]   fill;
    logic [CNT_W-1:0]    dropped;
    logic [CNT_W-1:0]    underflow;
  } frame_result_t;

  typedef struct {
    bit                  is_cfg;
    bit                  cfg_val;
    op_t                 op;
    bit                  first;
    logic [LEN_W-1:0]    len;
    logic [SAMPLE_W-1:0] l;
    logic [SAMPLE_W-1:0] r;
    bit                  typed;
    frame_result_t       want;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic                  cfg_data = 1'b0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [1:0]            s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [0:0]            m_tuser;

  // mirror of the ring and its bookkeeping
  logic [WORD_W-1:0]   mirror_ring [RING_FRAMES];
  logic [PTR_W-1:0]    mirror_wr = '0;
  logic [PTR_W-1:0]    mirror_rd = '0;
  bit                  mirror_flush = 1'b1;
  bit                  mirror_block_ok = 1'b0;
  bit                  mirror_bypass = 1'b0;
  bit                  mirror_enable = 1'b0;
  logic [CNT_W-1:0]    mirror_dropped = '0;
  logic [CNT_W-1:0]    mirror_underflow = '0;

  frame_result_t awaited_frames[$];
  stim_row_t     dir_table[$];
  frame_result_t unchecked_row = '{default: '0};
  int            mismatch_count = 0;
  int            frames_sent = 0;
  bit            sender_gaps = 1'b1;
  bit            sink_stalls = 1'b1;
  int            stall_left = 0;

  monitor_fifo_attenuated_mixer_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [SAMPLE_W-1:0] sat16(input int v);
    if (v > SAMPLE_MAX) return SAMPLE_W'(SAMPLE_MAX);
    if (v < SAMPLE_MIN) return SAMPLE_W'(SAMPLE_MIN);
    return SAMPLE_W'(v);
  endfunction

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return SAMPLE_W'(int'($urandom_range(0, 8)) - 4);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic advance_ring_mirror(input op_t op, input bit first,
                                     input logic [LEN_W-1:0] len,
                                     input logic [SAMPLE_W-1:0] l, r,
                                     output frame_result_t res);
    logic [PTR_W-1:0]  used;
    logic [WORD_W-1:0] word;
    int                ml;
    int                mr;
    res.left = '0;
    res.right = '0;
    res.took = 1'b0;
    used = mirror_wr - mirror_rd;
    if (op == OP_PUSH) begin
      if (first) begin
        if (len == 0) begin
          mirror_block_ok = 1'b0;
        end else if (int'(len) > RING_FRAMES - 1 - int'(used)) begin
          mirror_block_ok = 1'b0;
          mirror_dropped += CNT_W'(len);
        end else begin
          mirror_block_ok = 1'b1;
        end
      end
      if (mirror_block_ok && int'(used) < RING_FRAMES - 1) begin
        mirror_ring[mirror_wr] = {r, l};
        mirror_wr = mirror_wr + 1'b1;
        res.took = 1'b1;
      end
    end else begin
      res.left = l;
      res.right = r;
      if (first) begin
        if (len == 0) begin
          mirror_bypass = 1'b1;
        end else if (!mirror_enable || mirror_flush) begin
          mirror_rd = mirror_wr;
          mirror_flush = 1'b0;
          mirror_bypass = 1'b1;
        end else begin
          mirror_bypass = 1'b0;
        end
      end
      if (!mirror_bypass) begin
        if (mirror_wr != mirror_rd) begin
          word = mirror_ring[mirror_rd];
          ml = $signed(word[SAMPLE_W-1:0]);
          mr = $signed(word[WORD_W-1:SAMPLE_W]);
          res.left = sat16(int'($signed(l)) + (ml * 3) / 4);
          res.right = sat16(int'($signed(r)) + (mr * 3) / 4);
          mirror_rd = mirror_rd + 1'b1;
          res.took = 1'b1;
        end else begin
          mirror_underflow += 1;
        end
      end
    end
    res.fill = mirror_wr - mirror_rd;
    res.dropped = mirror_dropped;
    res.underflow = mirror_underflow;
  endtask

  task automatic send_frame(input op_t op, input bit first, input logic [LEN_W-1:0] len,
                            input logic [SAMPLE_W-1:0] l, r,
                            input bit typed, input frame_result_t want);
    frame_result_t        predicted;
    logic [IN_DATA_W-1:0] word;
    if (sender_gaps && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    word = '0;
    word[LEN_W-1:0] = len;
    word[LEN_W +: SAMPLE_W] = l;
    word[LEN_W + SAMPLE_W +: SAMPLE_W] = r;
    s_tdata <= word;
    s_tuser <= {first, op};
    s_tvalid <= 1'b1;
    advance_ring_mirror(op, first, len, l, r, predicted);
    awaited_frames.push_back(typed ? want : predicted);
    frames_sent++;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_block(input op_t op, input logic [LEN_W-1:0] len, input int count);
    for (int k = 0; k < count; k++) begin
      send_frame(op, k == 0, len, rand_sample(), rand_sample(), 1'b0, unchecked_row);
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (awaited_frames.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_enable(input bit en);
    cfg_data <= en;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    mirror_flush = 1'b1;
    mirror_enable = en;
  endtask

  // typed rows: push gives zero audio, mix passes the host frame through
  task automatic add_row(input op_t op, input bit first, input logic [LEN_W-1:0] len,
                         input logic [SAMPLE_W-1:0] l, r, input bit typed,
                         input bit took, input logic [FILL_W-1:0] fill,
                         input logic [CNT_W-1:0] dropped, input logic [CNT_W-1:0] underflow);
    stim_row_t row;
    row.is_cfg = 1'b0;
    row.cfg_val = 1'b0;
    row.op = op;
    row.first = first;
    row.len = len;
    row.l = l;
    row.r = r;
    row.typed = typed;
    row.want.left = (op == OP_MIX) ? l : '0;
    row.want.right = (op == OP_MIX) ? r : '0;
    row.want.took = took;
    row.want.fill = fill;
    row.want.dropped = dropped;
    row.want.underflow = underflow;
    dir_table.push_back(row);
  endtask

  task automatic add_cfg(input bit en);
    stim_row_t row;
    row = '{default: '0, op: OP_PUSH, want: unchecked_row};
    row.is_cfg = 1'b1;
    row.cfg_val = en;
    dir_table.push_back(row);
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 18) - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : result_check
    frame_result_t got;
    frame_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.left = m_tdata[LEFT_LO +: SAMPLE_W];
      got.right = m_tdata[RIGHT_LO +: SAMPLE_W];
      got.took = m_tuser[0];
      got.fill = m_tdata[FILL_LO +: FILL_W];
      got.dropped = m_tdata[DROP_LO +: CNT_W];
      got.underflow = m_tdata[UFLOW_LO +: CNT_W];
      if (awaited_frames.size() == 0) begin
        $display("%0t: result transfer with nothing expected: l=%h r=%h took=%b fill=%0d",
                 $time, got.left, got.right, got.took, got.fill);
        mismatch_count++;
      end else begin
        want = awaited_frames.pop_front();
        if (got.left !== want.left || got.right !== want.right || got.took !== want.took ||
            got.fill !== want.fill || got.dropped !== want.dropped ||
            got.underflow !== want.underflow) begin
          $display("%0t: mismatch expected l=%h r=%h took=%b fill=%0d drop=%0d uflow=%0d",
                   $time, want.left, want.right, want.took, want.fill, want.dropped,
                   want.underflow);
          $display("%0t:          actual   l=%h r=%h took=%b fill=%0d drop=%0d uflow=%0d",
                   $time, got.left, got.right, got.took, got.fill, got.dropped,
                   got.underflow);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #8_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int               pick;
    int               sz;
    int               shape;
    int               count;
    int               fill_len;
    int               phase_target;
    logic [LEN_W-1:0] len;
    logic [PTR_W-1:0] used;
    op_t              op;
    bit               en;

    // mix before any call start, zero and oversize push blocks, orphan push
    add_row(OP_MIX,  1'b0, 13'd1,    16'h04d2, 16'hfb2e, 1'b1, 1'b0, 12'd0, 32'd0, 32'd1);
    add_row(OP_PUSH, 1'b1, 13'd0,    16'h0007, 16'h0007, 1'b1, 1'b0, 12'd0, 32'd0, 32'd1);
    add_row(OP_PUSH, 1'b1, 13'd4096, 16'h1234, 16'h4321, 1'b1, 1'b0, 12'd0, 32'd4096, 32'd1);
    add_row(OP_PUSH, 1'b0, 13'd4096, 16'h5555, 16'haaaa, 1'b1, 1'b0, 12'd0, 32'd4096, 32'd1);
    add_row(OP_PUSH, 1'b1, 13'd3,    16'h7fff, 16'h8000, 1'b1, 1'b1, 12'd1, 32'd4096, 32'd1);
    add_row(OP_PUSH, 1'b0, 13'd3,    16'h8000, 16'h7fff, 1'b1, 1'b1, 12'd2, 32'd4096, 32'd1);
    add_row(OP_PUSH, 1'b0, 13'd3,    16'hffff, 16'hfffb, 1'b1, 1'b1, 12'd3, 32'd4096, 32'd1);
    // block runs past its announced length
    add_row(OP_PUSH, 1'b0, 13'd3,    16'hfffc, 16'h0003, 1'b1, 1'b1, 12'd4, 32'd4096, 32'd1);
    // monitoring off: the call flushes and bypasses
    add_row(OP_MIX,  1'b1, 13'd2,    16'h0064, 16'hff9c, 1'b1, 1'b0, 12'd0, 32'd4096, 32'd1);
    add_row(OP_MIX,  1'b0, 13'd2,    16'h8000, 16'h7fff, 1'b1, 1'b0, 12'd0, 32'd4096, 32'd1);
    add_cfg(1'b1);
    add_row(OP_PUSH, 1'b1, 13'd5,    16'h7fff, 16'h8000, 1'b1, 1'b1, 12'd1, 32'd4096, 32'd1);
    // pending flush at call start
    add_row(OP_MIX,  1'b1, 13'd1,    16'h0001, 16'hffff, 1'b1, 1'b0, 12'd0, 32'd4096, 32'd1);
    add_row(OP_PUSH, 1'b1, 13'd5,    16'h7fff, 16'h8000, 1'b1, 1'b1, 12'd1, 32'd4096, 32'd1);
    add_row(OP_PUSH, 1'b0, 13'd5,    16'h8000, 16'h7fff, 1'b1, 1'b1, 12'd2, 32'd4096, 32'd1);
    add_row(OP_PUSH, 1'b0, 13'd5,    16'hffff, 16'hfffb, 1'b1, 1'b1, 12'd3, 32'd4096, 32'd1);
    add_row(OP_PUSH, 1'b0, 13'd5,    16'hfffc, 16'h0004, 1'b1, 1'b1, 12'd4, 32'd4096, 32'd1);
    add_row(OP_PUSH, 1'b0, 13'd5,    16'h0001, 16'hffff, 1'b1, 1'b1, 12'd5, 32'd4096, 32'd1);
    // zero-length call bypasses without a flush
    add_row(OP_MIX,  1'b1, 13'd0,    16'h0009, 16'hfff7, 1'b1, 1'b0, 12'd5, 32'd4096, 32'd1);
    // saturation both ways
    add_row(OP_MIX,  1'b1, 13'd3,    16'h7fff, 16'h8000, 1'b0, 1'b0, 12'd0, 32'd0, 32'd0);
    add_row(OP_MIX,  1'b0, 13'd3,    16'h8000, 16'h7fff, 1'b0, 1'b0, 12'd0, 32'd0, 32'd0);
    // enable written mid-call: call keeps using the ring, truncation toward zero
    add_cfg(1'b1);
    add_row(OP_MIX,  1'b0, 13'd3,    16'h0000, 16'h0000, 1'b0, 1'b0, 12'd0, 32'd0, 32'd0);
    add_row(OP_MIX,  1'b1, 13'd2,    16'h1111, 16'h2222, 1'b1, 1'b0, 12'd0, 32'd4096, 32'd1);
    // empty ring while mixing
    add_row(OP_MIX,  1'b1, 13'd4,    16'h0005, 16'hfffb, 1'b1, 1'b0, 12'd0, 32'd4096, 32'd2);
    add_cfg(1'b0);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_table[i]) begin
      if (dir_table[i].is_cfg) begin
        drain();
        write_enable(dir_table[i].cfg_val);
      end else begin
        send_frame(dir_table[i].op, dir_table[i].first, dir_table[i].len, dir_table[i].l,
                   dir_table[i].r, dir_table[i].typed, dir_table[i].want);
      end
    end

    phase_target = frames_sent;
    for (int phase = 0; phase < 10; phase++) begin
      drain();
      if (phase == 3) en = 1'b0;
      else if (phase == 0 || phase == 5 || phase == 9) en = 1'b1;
      else en = ($urandom_range(0, 3) != 0);
      write_enable(en);
      sender_gaps = (phase < 9);
      sink_stalls = (phase < 9);
      phase_target += 130;
      while (frames_sent < phase_target) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          send_frame(op_t'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     LEN_W'($urandom_range(0, 8191)), rand_sample(), rand_sample(),
                     1'b0, unchecked_row);
        end else begin
          op = (pick < 54) ? OP_PUSH : OP_MIX;
          sz = $urandom_range(0, 19);
          if (sz == 0) len = '0;
          else if (sz < 3) len = LEN_W'($urandom_range(0, 8191));
          else len = LEN_W'($urandom_range(1, 40));
          if (len > 64) begin
            count = $urandom_range(1, 6);
          end else begin
            shape = $urandom_range(0, 9);
            if (shape == 0) count = int'(len) + $urandom_range(1, 3);
            else if (shape == 1 && len > 1) count = $urandom_range(1, int'(len) - 1);
            else count = int'(len);
          end
          if (count == 0) count = 1;
          send_block(op, len, count);
        end
      end
      if (phase == 5) begin
        // fill the ring to the brim, overrun it, then read at full
        send_block(OP_MIX, LEN_W'(1), 1);
        used = mirror_wr - mirror_rd;
        fill_len = RING_FRAMES - 1 - int'(used);
        send_block(OP_PUSH, LEN_W'((fill_len == 0) ? 1 : fill_len), fill_len + 3);
        send_block(OP_PUSH, LEN_W'(1), 2);
        send_block(OP_MIX, LEN_W'(8), 8);
      end
    end

    drain();
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: sim.f
rtl/mfam_pkg.sv
rtl/mfam_ram.sv
rtl/mfam_ctrl.sv
rtl/mfam_mix.sv
rtl/monitor_fifo_attenuated_mixer_unit.sv
tb/monitor_fifo_attenuated_mixer_unit_test.sv
